>>> rtl/lrusac_pkg.sv
// lrusac_pkg: shared types, codes and helpers of the lru cache simulator
// used by the controller, datapath, top level and bench; depends on nothing
`timescale 1ns / 1ps

package lrusac_pkg;

	// register field widths and reset values
	localparam int SETB_W = 3;
	localparam int WAYS_W = 4;
	localparam int OFFB_W = 5;
	localparam logic [SETB_W-1:0] SETB_RESET = '0;
	localparam logic [WAYS_W-1:0] WAYS_RESET = WAYS_W'(1);
	localparam logic [OFFB_W-1:0] OFFB_RESET = '0;
	localparam int MAX_OFFSET_BITS = 16;

	// register index, taken from paddr[3:2]
	localparam logic [1:0] REG_SET_BITS = 2'd0;
	localparam logic [1:0] REG_WAYS = 2'd1;
	localparam logic [1:0] REG_OFFSET_BITS = 2'd2;

	localparam int CNT_W = 32;
	localparam int CMD_W = 2;
	localparam int OUTCOME_W = 2;
	// outcome, second hit, three totals
	localparam int OUT_FIELDS_W = OUTCOME_W + 1 + 3 * CNT_W;
	localparam int OUT_W = ((OUT_FIELDS_W + 7) / 8) * 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_FETCH = 2'd0,
		CMD_STORE = 2'd1,
		CMD_LOAD = 2'd2,
		CMD_MODIFY = 2'd3
	} cmd_t;

	typedef enum logic [OUTCOME_W-1:0] {
		RES_HIT = 2'd0,
		RES_FILL = 2'd1,
		RES_EVICT = 2'd2,
		RES_IGNORED = 2'd3
	} outcome_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COMPARE,
		ST_UPDATE,
		ST_HOLD
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic compare;
		logic update;
		logic load_out;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_busy;
	} dp_status_t;

	// saturating add of 0..3
	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
			input logic [1:0] inc);
		logic [CNT_W:0] s;
		s = {1'b0, v} + {{(CNT_W - 1){1'b0}}, inc};
		return s[CNT_W] ? '1 : s[CNT_W-1:0];
	endfunction

endpackage

>>> rtl/lrusac_mem.sv
// lrusac_mem: set store, one row per set holding all ways, with per-row written flags
// registered read; depends on nothing but its parameters
`timescale 1ns / 1ps

module lrusac_mem #(
	parameter int SET_W = 6,
	parameter int NUM_SETS = 64,
	parameter int ROW_W = 648
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [SET_W-1:0] rd_addr,
	output logic [ROW_W-1:0] rd_data,
	output logic             rd_ok,
	input  logic             wr_en,
	input  logic [SET_W-1:0] wr_addr,
	input  logic [ROW_W-1:0] wr_data
);

	logic [ROW_W-1:0] mem [NUM_SETS];
	logic [NUM_SETS-1:0] row_ok_q;
	logic [ROW_W-1:0] rd_data_q;
	logic rd_ok_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// a row never written reads back with rd_ok low
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_ok_q <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			if (wr_en) begin
				row_ok_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_ok_q <= row_ok_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_data_q;
	assign rd_ok = rd_ok_q;

endmodule

>>> rtl/lrusac_dp.sv
// lrusac_dp: address split, way compare, lru victim select, counters, result register
// depends on lrusac_pkg and lrusac_mem
`timescale 1ns / 1ps

module lrusac_dp
	import lrusac_pkg::*;
#(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS = 8,
	parameter int ADDR_WIDTH = 48,
	parameter int IN_W = 56
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ctrl_cmd_t         ctl,
	output dp_status_t        st,
	input  logic [SETB_W-1:0] cfg_set_bits,
	input  logic [WAYS_W-1:0] cfg_ways,
	input  logic [OFFB_W-1:0] cfg_offset_bits,
	input  logic [IN_W-1:0]   in_data,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [OUT_W-1:0]  out_data
);

	localparam int ENT_W = 1 + ADDR_WIDTH + CNT_W;
	localparam int ROW_W = MAX_WAYS * ENT_W;
	localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int NUM_SETS = 1 << MAX_SET_BITS;
	localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int TREE_N = 1 << WAY_W;
	localparam int WCNT_W = $clog2(MAX_WAYS + 1);

	// captured access
	cmd_t cmd_q;
	logic [ADDR_WIDTH-1:0] tag_q;
	logic [SET_W-1:0] set_q;

	// compare stage results
	logic [MAX_WAYS-1:0] match_s2, free_s2, en_s2;
	logic [CNT_W-1:0] age_s2 [MAX_WAYS];

	// totals and last result
	logic [CNT_W-1:0] clock_q, hit_q, miss_q, evict_q;
	outcome_t outcome_q;
	logic second_q;
	logic out_valid_q;
	logic [OUT_W-1:0] out_data_q;

	// address split
	logic [ADDR_WIDTH-1:0] addr_in, addr_sh;
	logic [4:0] sb_eff, bb_eff;
	logic [SET_W-1:0] set_mask, set_next;
	logic [ADDR_WIDTH-1:0] tag_next;

	always_comb begin
		addr_in = in_data[CMD_W +: ADDR_WIDTH];
		sb_eff = (int'(cfg_set_bits) > MAX_SET_BITS) ? 5'(MAX_SET_BITS) : 5'(cfg_set_bits);
		bb_eff = (int'(cfg_offset_bits) > MAX_OFFSET_BITS) ? 5'(MAX_OFFSET_BITS)
			: cfg_offset_bits;
		for (int i = 0; i < SET_W; i++) begin
			set_mask[i] = (i < int'(sb_eff));
		end
		addr_sh = addr_in >> bb_eff;
		set_next = addr_sh[SET_W-1:0] & set_mask;
		tag_next = addr_in >> (6'(sb_eff) + 6'(bb_eff));
	end

	// set store
	logic [ROW_W-1:0] rd_row, wr_row;
	logic rd_ok, wr_en;

	lrusac_mem #(
		.SET_W(SET_W),
		.NUM_SETS(NUM_SETS),
		.ROW_W(ROW_W)
	) u_mem (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(ctl.capture),
		.rd_addr(set_next),
		.rd_data(rd_row),
		.rd_ok(rd_ok),
		.wr_en(wr_en),
		.wr_addr(set_q),
		.wr_data(wr_row)
	);

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q <= cmd_t'(in_data[CMD_W-1:0]);
			tag_q <= tag_next;
			set_q <= set_next;
		end
	end

	// compare: per-way match, free and age against the advanced clock
	logic [WCNT_W-1:0] nw_eff;
	logic [CNT_W-1:0] clock_inc;
	logic [MAX_WAYS-1:0] match_c, free_c, en_c;
	logic [CNT_W-1:0] age_c [MAX_WAYS];
	logic [ENT_W-1:0] ent;

	always_comb begin
		if (cfg_ways == '0) begin
			nw_eff = WCNT_W'(1);
		end else if (int'(cfg_ways) > MAX_WAYS) begin
			nw_eff = WCNT_W'(MAX_WAYS);
		end else begin
			nw_eff = WCNT_W'(cfg_ways);
		end
		clock_inc = clock_q + CNT_W'(1);
		ent = '0;
		for (int w = 0; w < MAX_WAYS; w++) begin
			ent = rd_row[w*ENT_W +: ENT_W];
			en_c[w] = (w < int'(nw_eff));
			match_c[w] = en_c[w] && rd_ok && ent[ENT_W-1]
				&& (ent[ENT_W-2:CNT_W] == tag_q);
			free_c[w] = en_c[w] && !(rd_ok && ent[ENT_W-1]);
			age_c[w] = clock_inc - ent[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.compare) begin
			match_s2 <= match_c;
			free_s2 <= free_c;
			en_s2 <= en_c;
			for (int w = 0; w < MAX_WAYS; w++) begin
				age_s2[w] <= age_c[w];
			end
		end
	end

	// victim: registered ages through a pairwise tree, lower way wins ties
	logic [TREE_N-1:0] t_en;
	logic [CNT_W-1:0] t_age [TREE_N];
	logic [WAY_W-1:0] t_idx [TREE_N];

	always_comb begin
		for (int i = 0; i < TREE_N; i++) begin
			t_en[i] = (i < MAX_WAYS) ? en_s2[i % MAX_WAYS] : 1'b0;
			t_age[i] = age_s2[i % MAX_WAYS];
			t_idx[i] = WAY_W'(i);
		end
		for (int lvl = 0; lvl < WAY_W; lvl++) begin
			for (int i = 0; i < TREE_N; i += (2 << lvl)) begin
				if (!(t_en[i] && (!t_en[i + (1 << lvl)]
						|| t_age[i] >= t_age[i + (1 << lvl)]))) begin
					t_en[i] = t_en[i + (1 << lvl)];
					t_age[i] = t_age[i + (1 << lvl)];
					t_idx[i] = t_idx[i + (1 << lvl)];
				end
			end
		end
	end

	// update: pick way, rebuild row, advance totals
	logic is_fetch, is_mod, hit, have_free;
	logic [WAY_W-1:0] hit_way, free_way, sel_way;
	logic [MAX_WAYS-1:0] sel_mask;
	logic [CNT_W-1:0] new_last;
	outcome_t outcome_new;
	logic [1:0] hit_inc, miss_inc, evict_inc;
	logic [CNT_W-1:0] clock_d, hit_d, miss_d, evict_d;
	outcome_t outcome_d;
	logic second_d;

	always_comb begin
		is_fetch = (cmd_q == CMD_FETCH);
		is_mod = (cmd_q == CMD_MODIFY);
		hit = |match_s2;
		have_free = |free_s2;
		hit_way = '0;
		free_way = '0;
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (match_s2[w]) begin
				hit_way = WAY_W'(w);
			end
			if (free_s2[w]) begin
				free_way = WAY_W'(w);
			end
		end
		priority if (hit) begin
			sel_way = hit_way;
			outcome_new = RES_HIT;
		end else if (have_free) begin
			sel_way = free_way;
			outcome_new = RES_FILL;
		end else begin
			sel_way = t_idx[0];
			outcome_new = RES_EVICT;
		end
		if (is_fetch) begin
			outcome_new = RES_IGNORED;
		end
		// a modify's second lookup hits the same way one tick later
		new_last = clock_q + (is_mod ? CNT_W'(2) : CNT_W'(1));
		wr_row = rd_ok ? rd_row : '0;
		for (int w = 0; w < MAX_WAYS; w++) begin
			sel_mask[w] = (WAY_W'(w) == sel_way);
			if (sel_mask[w]) begin
				wr_row[w*ENT_W +: ENT_W] = {1'b1, tag_q, new_last};
			end
		end
		wr_en = ctl.update && !is_fetch;
		hit_inc = is_fetch ? 2'd0 : {1'b0, hit} + {1'b0, is_mod};
		miss_inc = {1'b0, !is_fetch && !hit};
		evict_inc = {1'b0, !is_fetch && !hit && !have_free};
		if (ctl.update) begin
			clock_d = is_fetch ? clock_q : new_last;
			hit_d = sat_add(hit_q, hit_inc);
			miss_d = sat_add(miss_q, miss_inc);
			evict_d = sat_add(evict_q, evict_inc);
			outcome_d = outcome_new;
			second_d = is_mod;
		end else begin
			clock_d = clock_q;
			hit_d = hit_q;
			miss_d = miss_q;
			evict_d = evict_q;
			outcome_d = outcome_q;
			second_d = second_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= '0;
			hit_q <= '0;
			miss_q <= '0;
			evict_q <= '0;
			outcome_q <= RES_IGNORED;
			second_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			clock_q <= clock_d;
			hit_q <= hit_d;
			miss_q <= miss_d;
			evict_q <= evict_d;
			outcome_q <= outcome_d;
			second_q <= second_d;
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			out_data_q <= OUT_W'({evict_d, miss_d, hit_d, second_d, outcome_d});
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;
	assign st.out_busy = out_valid_q && !out_ready;

	a_one_way_written: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> $onehot(sel_mask))
		else $error("row write does not select exactly one way");

	a_clock_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.update && cmd_q != CMD_FETCH) |=> clock_q != $past(clock_q))
		else $error("access clock did not advance on a lookup");

	a_hits_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> hit_q >= $past(hit_q))
		else $error("hit total decreased");

endmodule

>>> rtl/lrusac_ctrl.sv
// lrusac_ctrl: sequencer for capture, compare, update and result hand-off
// depends on lrusac_pkg
`timescale 1ns / 1ps

module lrusac_ctrl
	import lrusac_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t st,
	output ctrl_cmd_t  ctl
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		unique case (state_q)
			ST_IDLE: begin
				state_d = in_valid ? ST_COMPARE : ST_IDLE;
			end
			ST_COMPARE: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE, ST_HOLD: begin
				state_d = st.out_busy ? ST_HOLD : ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		ctl = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				ctl.capture = in_valid;
			end
			ST_COMPARE: begin
				ctl.compare = 1'b1;
			end
			ST_UPDATE: begin
				ctl.update = 1'b1;
				ctl.load_out = !st.out_busy;
			end
			ST_HOLD: begin
				ctl.load_out = !st.out_busy;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	a_compare_then_update: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COMPARE |=> state_q == ST_UPDATE)
		else $error("compare not followed by update");

	a_hold_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_HOLD |-> ($past(state_q) == ST_UPDATE || $past(state_q) == ST_HOLD))
		else $error("hold entered without an update");

endmodule

>>> rtl/lru_set_assoc_cache_sim.sv
// lru_set_assoc_cache_sim: top level with apb register block, controller and datapath
// depends on lrusac_pkg, lrusac_ctrl, lrusac_dp
`timescale 1ns / 1ps

// Set-associative cache simulator with least-recently-used replacement. Each input word
// is one access (command, byte address); each produces exactly one output word with the
// first lookup outcome (0 hit, 1 miss filling the lowest free way, 2 miss evicting the
// oldest way, 3 fetch ignored), a flag set for a modify (its second lookup always hits)
// and saturating hit, miss and eviction totals after the access. The address is split
// by the set_index_bits and block_offset_bits registers; ways_in_use limits the ways
// searched and replaced. Registers sit at byte addresses 0, 4 and 8 and must only be
// written while no access is in flight. An access runs through capture with the set
// row read from the store, tag compare and age compute, then victim select with the row
// write-back and result hand-off; the result register holds the block only if the
// previous word has not been taken yet. The whole set is one memory row, so an access
// costs one read of the store and, unless a fetch, one write. The store needs no clearing
// pass: a per-set written flag, cleared by reset, makes untouched sets read as empty.

module lru_set_assoc_cache_sim
	import lrusac_pkg::*;
#(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS = 8,
	parameter int ADDR_WIDTH = 48
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// apb configuration port
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [3:0]                            paddr,
	input  logic [31:0]                           pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready,
	// access stream
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// command [1:0], address [ADDR_WIDTH+1:2], zero padding above
	input  logic [((CMD_W + ADDR_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
	// result stream
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// first_outcome [1:0], second_hit [2], hit_total [34:3], miss_total [66:35],
	// eviction_total [98:67], zero padding above
	output logic [OUT_W-1:0]                      m_axis_tdata
);

	localparam int IN_W = ((CMD_W + ADDR_WIDTH + 7) / 8) * 8;

	// configuration registers
	logic [SETB_W-1:0] set_bits_q;
	logic [WAYS_W-1:0] ways_q;
	logic [OFFB_W-1:0] offset_bits_q;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q <= SETB_RESET;
			ways_q <= WAYS_RESET;
			offset_bits_q <= OFFB_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_SET_BITS: set_bits_q <= pwdata[SETB_W-1:0];
				REG_WAYS: ways_q <= pwdata[WAYS_W-1:0];
				REG_OFFSET_BITS: offset_bits_q <= pwdata[OFFB_W-1:0];
				default: begin
					// no register here, write dropped
				end
			endcase
		end
	end

	// read back, zero extended
	always_comb begin
		unique case (paddr[3:2])
			REG_SET_BITS: prdata = 32'(set_bits_q);
			REG_WAYS: prdata = 32'(ways_q);
			REG_OFFSET_BITS: prdata = 32'(offset_bits_q);
			default: prdata = '0;
		endcase
	end

	// controller and datapath talk only through these
	ctrl_cmd_t ctl;
	dp_status_t st;

	lrusac_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.st(st),
		.ctl(ctl)
	);

	lrusac_dp #(
		.MAX_SET_BITS(MAX_SET_BITS),
		.MAX_WAYS(MAX_WAYS),
		.ADDR_WIDTH(ADDR_WIDTH),
		.IN_W(IN_W)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.st(st),
		.cfg_set_bits(set_bits_q),
		.cfg_ways(ways_q),
		.cfg_offset_bits(offset_bits_q),
		.in_data(s_axis_tdata),
		.out_ready(m_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_data(m_axis_tdata)
	);

endmodule

>>> tb/lru_set_assoc_cache_sim_test.sv
// lru_set_assoc_cache_sim_test: self-checking bench for the lru cache simulator, with a
// directed opening, randomized access streams over several register settings and stalls
// depends on lrusac_pkg and lru_set_assoc_cache_sim
`timescale 1ns / 1ps

module lru_set_assoc_cache_sim_test;
	import lrusac_pkg::*;

	localparam int SET_BITS_MAX = 6;
	localparam int WAYS_MAX = 8;
	localparam int ADDR_W = 48;
	localparam int LINE_COUNT = (1 << SET_BITS_MAX) * WAYS_MAX;
	localparam int IN_W = ((CMD_W + ADDR_W + 7) / 8) * 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 20;
	localparam int REPORT_MAX = 10;
	localparam int PHASE_WORDS = 75;
	localparam int PHASE_COUNT = 8;
	localparam int TAG_POOL = 12;
	localparam int SET_POOL = 4;

	typedef struct {
		cmd_t cmd;
		logic [ADDR_W-1:0] addr;
	} access_t;

	typedef struct {
		outcome_t first;
		logic second_hit;
		logic [CNT_W-1:0] hits;
		logic [CNT_W-1:0] misses;
		logic [CNT_W-1:0] evictions;
	} result_t;

	// ports, every input known from time zero
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	// command [1:0], address [49:2], zero padding above
	logic [IN_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// first_outcome [1:0], second_hit [2], hit_total [34:3], miss_total [66:35],
	// eviction_total [98:67], zero padding above
	logic [OUT_W-1:0] m_axis_tdata;

	lru_set_assoc_cache_sim #(
		.MAX_SET_BITS(SET_BITS_MAX),
		.MAX_WAYS(WAYS_MAX),
		.ADDR_WIDTH(ADDR_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow of the register block, same reset values as the hardware
	logic [SETB_W-1:0] cfg_set_bits = SETB_RESET;
	logic [WAYS_W-1:0] cfg_ways = WAYS_RESET;
	logic [OFFB_W-1:0] cfg_offset_bits = OFFB_RESET;

	// shadow cache store, line = set * WAYS_MAX + way, all zero like after reset
	bit way_valid [LINE_COUNT];
	bit [ADDR_W-1:0] way_tag [LINE_COUNT];
	bit [CNT_W-1:0] way_stamp [LINE_COUNT];
	bit [CNT_W-1:0] lookup_clock;
	bit [CNT_W-1:0] hit_sum;
	bit [CNT_W-1:0] miss_sum;
	bit [CNT_W-1:0] evict_count;

	access_t pending_accesses [$];
	result_t expected_results [$];
	access_t staged_access;

	int send_idle_pct = 35;
	int recv_idle_pct = 65;
	int mismatches = 0;
	int words_in = 0;
	int words_out = 0;
	int modifies_in = 0;
	int settings_used = 1;
	int cycle_count = 0;
	int outcome_tally [4];

	// out-of-range register values fold onto the nearest legal geometry
	function automatic void effective_geometry(output int sb, output int bb, output int nw);
		sb = (cfg_set_bits > SET_BITS_MAX) ? SET_BITS_MAX : int'(cfg_set_bits);
		bb = (cfg_offset_bits > MAX_OFFSET_BITS) ? MAX_OFFSET_BITS : int'(cfg_offset_bits);
		if (cfg_ways == 0)
			nw = 1;
		else
			nw = (cfg_ways > WAYS_MAX) ? WAYS_MAX : int'(cfg_ways);
	endfunction

	function automatic bit [CNT_W-1:0] sat_bump(input bit [CNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// one lookup against the shadow store; updates recency, tags and totals
	function automatic outcome_t cache_lookup(input logic [ADDR_W-1:0] addr);
		int sb, bb, nw, base, victim, free_way;
		logic [ADDR_W-1:0] tag_v;
		bit [CNT_W-1:0] age, best_age;
		effective_geometry(sb, bb, nw);
		base = int'((64'(addr) >> bb) & ((64'd1 << sb) - 1)) * WAYS_MAX;
		tag_v = addr >> (sb + bb);
		lookup_clock = lookup_clock + 1'b1;
		for (int w = 0; w < nw; w++) begin
			if (way_valid[base + w] && way_tag[base + w] == tag_v) begin
				way_stamp[base + w] = lookup_clock;
				hit_sum = sat_bump(hit_sum);
				return RES_HIT;
			end
		end
		miss_sum = sat_bump(miss_sum);
		// lowest free way wins
		free_way = -1;
		for (int w = nw - 1; w >= 0; w--)
			if (!way_valid[base + w])
				free_way = w;
		if (free_way >= 0) begin
			way_valid[base + free_way] = 1'b1;
			way_tag[base + free_way] = tag_v;
			way_stamp[base + free_way] = lookup_clock;
			return RES_FILL;
		end
		// oldest way goes, ties to the lowest way
		victim = 0;
		best_age = lookup_clock - way_stamp[base];
		for (int w = 1; w < nw; w++) begin
			age = lookup_clock - way_stamp[base + w];
			if (age > best_age) begin
				best_age = age;
				victim = w;
			end
		end
		evict_count = sat_bump(evict_count);
		way_tag[base + victim] = tag_v;
		way_stamp[base + victim] = lookup_clock;
		return RES_EVICT;
	endfunction

	function automatic void predict_result(input access_t a);
		result_t r;
		r.first = RES_IGNORED;
		r.second_hit = 1'b0;
		if (a.cmd != CMD_FETCH) begin
			r.first = cache_lookup(a.addr);
			// modify: load lookup, then a store lookup of the same address
			if (a.cmd == CMD_MODIFY)
				r.second_hit = (cache_lookup(a.addr) == RES_HIT);
		end
		r.hits = hit_sum;
		r.misses = miss_sum;
		r.evictions = evict_count;
		expected_results.push_back(r);
	endfunction

	task automatic check_field(input string what, input logic [CNT_W-1:0] want_v,
			input logic [CNT_W-1:0] got_v);
		if (want_v !== got_v) begin
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what,
					want_v, got_v);
		end
	endtask

	// driver: one word staged at a time, a new one only once the old one is taken;
	// the prediction runs at the edge where the word is accepted
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_result(staged_access);
				words_in++;
				if (staged_access.cmd == CMD_MODIFY)
					modifies_in++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_accesses.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					staged_access = pending_accesses.pop_front();
					s_axis_tdata <= {{(IN_W - CMD_W - ADDR_W){1'b0}}, staged_access.addr,
						staged_access.cmd};
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// monitor: every accepted result word against the oldest prediction
	always @(posedge clk) begin : result_monitor
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			words_out++;
			outcome_tally[m_axis_tdata[1:0]]++;
			if (expected_results.size() == 0) begin
				check_field("predictions waiting for a result word", 1, 0);
			end else begin
				want = expected_results.pop_front();
				check_field("first_outcome", want.first, m_axis_tdata[1:0]);
				check_field("second_hit", want.second_hit, m_axis_tdata[2]);
				check_field("hit_total", want.hits, m_axis_tdata[34:3]);
				check_field("miss_total", want.misses, m_axis_tdata[66:35]);
				check_field("eviction_total", want.evictions, m_axis_tdata[98:67]);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("run stopped by watchdog after %0d cycles, %0d results still due",
				cycle_count, expected_results.size());
			$display("** lru_set_assoc_cache_sim: FAILED **");
			$finish;
		end
	end

	task automatic queue_access(input cmd_t c, input logic [ADDR_W-1:0] a);
		access_t item;
		item.cmd = c;
		item.addr = a;
		pending_accesses.push_back(item);
	endtask

	// apb write: setup cycle, access cycle, register taken at the end of access
	task automatic write_register(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_SET_BITS: cfg_set_bits = val[SETB_W-1:0];
			REG_WAYS: cfg_ways = val[WAYS_W-1:0];
			REG_OFFSET_BITS: cfg_offset_bits = val[OFFB_W-1:0];
			default: ;
		endcase
	endtask

	task automatic program_cache(input int sb, input int ways, input int ob);
		write_register(REG_SET_BITS, sb);
		write_register(REG_WAYS, ways);
		write_register(REG_OFFSET_BITS, ob);
		settings_used++;
	endtask

	// block until every queued word went in and every result came back
	task automatic drain();
		do
			@(negedge clk);
		while (pending_accesses.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
	endtask

	// mostly a few hot sets and a tag pool slightly larger than the associativity,
	// so hits, fills and evictions all show up; one word in ten is a wild address
	task automatic random_phase();
		logic [ADDR_W-1:0] tags [TAG_POOL];
		int set_pick [SET_POOL];
		int sb, bb, nw, pool;
		logic [63:0] a;
		cmd_t c;
		effective_geometry(sb, bb, nw);
		pool = nw + 2;
		for (int i = 0; i < TAG_POOL; i++)
			tags[i] = ADDR_W'({$urandom, $urandom});
		for (int i = 0; i < SET_POOL; i++)
			set_pick[i] = $urandom_range((1 << sb) - 1);
		for (int n = 0; n < PHASE_WORDS; n++) begin
			c = ($urandom_range(9) == 0) ? CMD_FETCH : cmd_t'($urandom_range(3, 1));
			if ($urandom_range(9) == 0)
				a = {$urandom, $urandom};
			else
				a = (64'(tags[$urandom_range(pool - 1)]) << (sb + bb))
					| (64'(set_pick[$urandom_range(SET_POOL - 1)]) << bb)
					| (64'($urandom) & ((64'd1 << bb) - 1));
			queue_access(c, a[ADDR_W-1:0]);
		end
	endtask

	initial begin
		logic [ADDR_W-1:0] set5_base;
		for (int i = 0; i < 4; i++)
			outcome_tally[i] = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset geometry: one set, one way, no offset, whole address is the tag
		queue_access(CMD_FETCH, '0);
		queue_access(CMD_STORE, '0);
		queue_access(CMD_LOAD, '0);
		queue_access(CMD_LOAD, '1);
		queue_access(CMD_MODIFY, '0);
		queue_access(CMD_FETCH, '1);
		drain();

		// widest geometry: fill all eight ways of one set, then age them out
		program_cache(SET_BITS_MAX, WAYS_MAX, MAX_OFFSET_BITS);
		set5_base = (48'd5 << MAX_OFFSET_BITS) | 48'h0abc;
		for (int t = 1; t <= WAYS_MAX; t++)
			queue_access(CMD_STORE, (48'(t) << (SET_BITS_MAX + MAX_OFFSET_BITS)) | set5_base);
		// refresh tag 1 so tag 2 becomes the oldest
		queue_access(CMD_LOAD, (48'd1 << (SET_BITS_MAX + MAX_OFFSET_BITS)) | set5_base);
		queue_access(CMD_STORE, (48'd9 << (SET_BITS_MAX + MAX_OFFSET_BITS)) | set5_base);
		queue_access(CMD_MODIFY, (48'd2 << (SET_BITS_MAX + MAX_OFFSET_BITS)) | set5_base);
		queue_access(CMD_LOAD, '1);
		drain();

		// every register over its range: must fold to the widest geometry and keep
		// the store, so both lookups hit lines left from the last setting
		program_cache(7, 15, 31);
		queue_access(CMD_LOAD, (48'd1 << (SET_BITS_MAX + MAX_OFFSET_BITS)) | set5_base);
		queue_access(CMD_MODIFY, '1);
		drain();

		// zero ways acts as one way
		program_cache(2, 0, 4);
		queue_access(CMD_STORE, '0);
		queue_access(CMD_LOAD, 48'h1230);
		queue_access(CMD_MODIFY, 48'h8000_0000_0000);
		drain();

		// random part, idling pattern changes at phase 3 and phase 6
		for (int p = 0; p < PHASE_COUNT; p++) begin
			if (p == 3) begin
				send_idle_pct = 65;
				recv_idle_pct = 35;
			end else if (p == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (p)
				0: program_cache(0, 1, 0);
				1: program_cache(SET_BITS_MAX, WAYS_MAX, MAX_OFFSET_BITS);
				2: program_cache(3, 4, 5);
				3: program_cache(7, 15, 31);
				4: program_cache(1, 2, 0);
				5: program_cache(4, 9, 12);
				6: program_cache(2, 0, 17);
				default: program_cache(5, WAYS_MAX, 3);
			endcase
			random_phase();
			drain();
		end

		// catch any stray word after the last expected one
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ran %0d access words (%0d modifies) through %0d register settings",
			words_in, modifies_in, settings_used);
		$display("first lookups: %0d hits, %0d fills, %0d evictions, %0d fetches; %0d mismatches",
			outcome_tally[RES_HIT], outcome_tally[RES_FILL], outcome_tally[RES_EVICT],
			outcome_tally[RES_IGNORED], mismatches);
		if (mismatches == 0 && expected_results.size() == 0 && words_out == words_in)
			$display("** lru_set_assoc_cache_sim: PASSED **");
		else
			$display("** lru_set_assoc_cache_sim: FAILED **");
		$finish;
	end

endmodule
